[rtl/prat_pkg.sv]
package prat_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;

  localparam int DIM_W      = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int QUO_W      = 8;
  localparam int SHIFT_W    = 3;
  localparam int NUM_W      = 40;
  localparam int DEN_W      = 34;

  localparam logic [CFG_IDX_W-1:0]  REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_DATA_W-1:0] FRAME_RESET      = 9'd256;

  typedef struct packed {
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
    logic [15:0] sample_red;
    logic [15:0] sample_green;
    logic [15:0] sample_blue;
  } sample_t;

  typedef struct packed {
    logic [7:0]  out_x;
    logic [7:0]  out_y;
    logic [7:0]  color_red;
    logic [7:0]  color_green;
    logic [7:0]  color_blue;
    logic [15:0] samples_so_far;
    logic        out_of_frame;
  } result_t;

  typedef struct packed {
    sample_t smp;
    logic    oof;
  } cmd_t;

  typedef struct packed {
    logic [31:0] sum_red;
    logic [31:0] sum_green;
    logic [31:0] sum_blue;
    logic [15:0] count;
  } entry_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

[rtl/pixel_radiance_accumulate_tonemap.sv]
// An in-frame sample passes the command FIFO, a pixel read-modify-write, the
// 8-step bit-serial divide and the result FIFO; an out-of-frame one skips the middle two.
// The back end takes one sample at a time: the next leaves the command FIFO only
// once the last one's result has entered the result FIFO.
// Reset: synchronous; afterwards the pixel store is cleared one entry a cycle
// with full held high.
module pixel_radiance_accumulate_tonemap #(
  parameter int MAX_WIDTH  = prat_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = prat_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  prat_pkg::sample_t               sample,
  output logic                            full,
  input  logic                            pop,
  output prat_pkg::result_t               result,
  output logic                            empty,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [prat_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prat_pkg::CFG_DATA_W-1:0] cfg_data
);

  prat_pkg::cmd_t         cmd;
  logic                   cmd_empty;
  logic                   cmd_pop;
  prat_pkg::back_status_t status;
  logic                   res_push;
  prat_pkg::result_t      res;
  logic                   res_full;
  logic [$bits(prat_pkg::result_t)-1:0] res_bits;

  assign cfg_ready = 1'b1;
  assign result    = prat_pkg::result_t'(res_bits);

  prat_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .sample    (sample),
    .full      (full),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd),
    .cmd_empty (cmd_empty)
  );

  prat_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_empty (cmd_empty),
    .cmd_pop   (cmd_pop),
    .status    (status),
    .res_push  (res_push),
    .res       (res),
    .res_full  (res_full)
  );

  prat_fifo #(.W($bits(prat_pkg::result_t))) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_bits),
    .empty (empty)
  );

endmodule

[rtl/prat_fifo.sv]
module prat_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  logic [W-1:0] data [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   cnt;
  logic         do_push;
  logic         do_pop;

  assign full    = (cnt == 2'd2);
  assign empty   = (cnt == 2'd0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = data[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      cnt  <= 2'd0;
    end else begin
      if (do_push) wptr <= !wptr;
      if (do_pop) rptr <= !rptr;
      if (do_push && !do_pop) cnt <= cnt + 2'd1;
      else if (do_pop && !do_push) cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) data[wptr] <= wdata;
  end

endmodule

[rtl/prat_front.sv]
module prat_front #(
  parameter int MAX_WIDTH  = prat_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = prat_pkg::DEF_MAX_HEIGHT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  input  prat_pkg::sample_t               sample,
  output logic                            full,
  input  logic                            cfg_valid,
  input  logic [prat_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [prat_pkg::CFG_DATA_W-1:0] cfg_data,
  input  prat_pkg::back_status_t          status,
  input  logic                            cmd_pop,
  output prat_pkg::cmd_t                  cmd,
  output logic                            cmd_empty
);

  localparam int DW = prat_pkg::DIM_W;

  logic [prat_pkg::CFG_DATA_W-1:0] frame_width;
  logic [prat_pkg::CFG_DATA_W-1:0] frame_height;
  logic [DW-1:0] w_lim;
  logic [DW-1:0] h_lim;
  logic          q_full;
  logic          cmd_push;
  prat_pkg::cmd_t cmd_in;
  logic [$bits(prat_pkg::cmd_t)-1:0] cmd_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= prat_pkg::FRAME_RESET;
      frame_height <= prat_pkg::FRAME_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        prat_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        prat_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    w_lim = (DW'(frame_width) > DW'(MAX_WIDTH)) ? DW'(MAX_WIDTH) : DW'(frame_width);
    h_lim = (DW'(frame_height) > DW'(MAX_HEIGHT)) ? DW'(MAX_HEIGHT) : DW'(frame_height);
    cmd_in.smp = sample;
    cmd_in.oof = (DW'(sample.pixel_x) >= w_lim) || (DW'(sample.pixel_y) >= h_lim);
  end

  // no items taken while the store is being cleared
  assign full     = q_full || status.clearing;
  assign cmd_push = push && !full;
  assign cmd      = prat_pkg::cmd_t'(cmd_bits);

  prat_fifo #(.W($bits(prat_pkg::cmd_t))) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_in),
    .full  (q_full),
    .pop   (cmd_pop),
    .rdata (cmd_bits),
    .empty (cmd_empty)
  );

endmodule

[rtl/prat_div.sv]
module prat_div (
  input  logic                          clk,
  input  logic                          load,
  input  logic                          step,
  input  logic [prat_pkg::SHIFT_W-1:0]  shift,
  input  logic [31:0]                   s,
  input  logic [15:0]                   n,
  output logic [prat_pkg::QUO_W-1:0]    quo
);

  localparam int NW = prat_pkg::NUM_W;
  localparam int DNW = prat_pkg::DEN_W;

  logic [NW-1:0]  rem;
  logic [DNW-1:0] den;
  logic [NW:0]    shifted;
  logic           ge;

  // restoring division, one quotient bit per step, MSB first
  always_comb begin
    shifted = (NW+1)'(den) << shift;
    ge      = {1'b0, rem} >= shifted;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rem <= {s, 8'h00} - NW'(s);
      den <= DNW'(s) + DNW'({n, 8'h00});
      quo <= '0;
    end else if (step && ge) begin
      rem        <= rem - shifted[NW-1:0];
      quo[shift] <= 1'b1;
    end
  end

endmodule

[rtl/prat_back.sv]
module prat_back #(
  parameter int MAX_WIDTH  = prat_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = prat_pkg::DEF_MAX_HEIGHT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  prat_pkg::cmd_t         cmd,
  input  logic                   cmd_empty,
  output logic                   cmd_pop,
  output prat_pkg::back_status_t status,
  output logic                   res_push,
  output prat_pkg::result_t      res,
  input  logic                   res_full
);

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_UPD   = 3'd2;
  localparam logic [2:0] ST_LOAD  = 3'd3;
  localparam logic [2:0] ST_DIV   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;

  prat_pkg::entry_t mem [DEPTH];
  prat_pkg::entry_t rd_data;
  prat_pkg::entry_t upd;
  prat_pkg::entry_t acc;
  prat_pkg::entry_t wdata;

  logic [2:0]        state;
  logic [ADDR_W-1:0] clr_addr;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] cur_addr;
  logic [ADDR_W-1:0] waddr;
  logic              we;
  prat_pkg::cmd_t    cur;
  logic [prat_pkg::SHIFT_W-1:0] step;
  logic              div_load;
  logic              div_step;
  logic [prat_pkg::QUO_W-1:0] q_red;
  logic [prat_pkg::QUO_W-1:0] q_green;
  logic [prat_pkg::QUO_W-1:0] q_blue;

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [15:0] b);
    logic [32:0] t;
    t = {1'b0, a} + 33'(b);
    return t[32] ? 32'hFFFF_FFFF : t[31:0];
  endfunction

  always_comb begin
    rd_addr = ADDR_W'(32'(cmd.smp.pixel_y) * 32'(MAX_WIDTH) + 32'(cmd.smp.pixel_x));
    cmd_pop = (state == ST_IDLE) && !cmd_empty;

    upd.sum_red   = sat_add(rd_data.sum_red, cur.smp.sample_red);
    upd.sum_green = sat_add(rd_data.sum_green, cur.smp.sample_green);
    upd.sum_blue  = sat_add(rd_data.sum_blue, cur.smp.sample_blue);
    upd.count     = (rd_data.count == 16'hFFFF) ? rd_data.count : rd_data.count + 16'd1;

    we    = (state == ST_CLEAR) || (state == ST_UPD);
    waddr = (state == ST_CLEAR) ? clr_addr : cur_addr;
    wdata = (state == ST_CLEAR) ? '0 : upd;

    div_load = (state == ST_LOAD);
    div_step = (state == ST_DIV);

    status.clearing = (state == ST_CLEAR);

    res_push           = (state == ST_OUT) && !res_full;
    res.out_x          = cur.smp.pixel_x;
    res.out_y          = cur.smp.pixel_y;
    res.color_red      = cur.oof ? '0 : q_red;
    res.color_green    = cur.oof ? '0 : q_green;
    res.color_blue     = cur.oof ? '0 : q_blue;
    res.samples_so_far = cur.oof ? '0 : acc.count;
    res.out_of_frame   = cur.oof;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (cmd_pop) rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur      <= cmd;
      cur_addr <= rd_addr;
    end
    if (state == ST_UPD) acc <= upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
      step     <= '0;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(DEPTH - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (!cmd_empty) state <= cmd.oof ? ST_OUT : ST_UPD;
        end
        ST_UPD: state <= ST_LOAD;
        ST_LOAD: begin
          step  <= '1;
          state <= ST_DIV;
        end
        ST_DIV: begin
          step <= step - prat_pkg::SHIFT_W'(1);
          if (step == '0) state <= ST_OUT;
        end
        ST_OUT: begin
          if (!res_full) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  prat_div u_div_red (
    .clk(clk), .load(div_load), .step(div_step), .shift(step),
    .s(acc.sum_red), .n(acc.count), .quo(q_red)
  );

  prat_div u_div_green (
    .clk(clk), .load(div_load), .step(div_step), .shift(step),
    .s(acc.sum_green), .n(acc.count), .quo(q_green)
  );

  prat_div u_div_blue (
    .clk(clk), .load(div_load), .step(div_step), .shift(step),
    .s(acc.sum_blue), .n(acc.count), .quo(q_blue)
  );

endmodule

[rtl/prat_checker.sv]
module prat_checker (
  input logic              clk,
  input logic              rst,
  input logic              full,
  input logic              pop,
  input logic              empty,
  input prat_pkg::result_t result
);

  // store clear keeps the input closed right after reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> full)
    else $error("input open right after reset");

  a_oof_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.out_of_frame) |->
      (result.color_red == 8'd0 && result.color_green == 8'd0 &&
       result.color_blue == 8'd0 && result.samples_so_far == 16'd0))
    else $error("out-of-frame transaction carries nonzero data");

  a_in_frame: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.out_of_frame) |->
      (result.samples_so_far != 16'd0 && result.color_red != 8'hFF &&
       result.color_green != 8'hFF && result.color_blue != 8'hFF))
    else $error("in-frame transaction out of range");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed");

endmodule

bind pixel_radiance_accumulate_tonemap prat_checker u_prat_checker (.*);
